[src/arenc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arenc_pkg
// Shared types and constants of the 16-bit binary arithmetic encoder.
// ----------------------------------------------------------------------------
package arenc_pkg;

  localparam int RANGE_W = 16;
  localparam int PROD_W  = 32;

  // Step counter of the iterative divider, one step per dividend bit.
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // Width of the follow counter limit; the counter itself is 8 bits wide.
  localparam int FOLLOW_BITS = 8;
  localparam logic [7:0] FOLLOW_MAX =
    (FOLLOW_BITS >= 8) ? 8'hff : 8'((1 << FOLLOW_BITS) - 1);

  localparam logic [RANGE_W-1:0] RANGE_HIGH_INIT = 16'hffff;
  localparam logic [RANGE_W-1:0] RANGE_LOW_INIT  = 16'h0000;
  localparam logic [8:0]         PACK_INIT       = 9'h001;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENCODE,
    KIND_SKIP,
    KIND_FINISH
  } item_kind_e;

  typedef struct packed {
    logic        command;
    logic [15:0] cum_low;
    logic [15:0] cum_high;
    logic [15:0] cum_total;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       follow_overflow;
  } out_item_t;

  // Classified item as it travels from the front to the back.
  typedef struct packed {
    item_kind_e  kind;
    logic [15:0] cum_low;
    logic [15:0] cum_high;
    logic [15:0] cum_total;
  } queue_item_t;

endpackage

[src/arenc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arenc_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit per
// cycle. Returns the low half of the quotient with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module arenc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [arenc_pkg::PROD_W-1:0]  dividend_i,
  input  logic [arenc_pkg::RANGE_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [arenc_pkg::RANGE_W-1:0] quot_o
);

  logic [arenc_pkg::PROD_W-1:0]    dq_q, dq_d;
  logic [arenc_pkg::RANGE_W-1:0]   rem_q, rem_d;
  logic [arenc_pkg::RANGE_W-1:0]   dvs_q, dvs_d;
  logic [arenc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;

  logic [arenc_pkg::RANGE_W:0]   shifted;
  logic [arenc_pkg::RANGE_W+1:0] diff;
  logic                          fits;

  assign shifted = {rem_q, dq_q[arenc_pkg::PROD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~diff[arenc_pkg::RANGE_W+1];

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[arenc_pkg::RANGE_W-1:0] : shifted[arenc_pkg::RANGE_W-1:0];
      dq_d  = {dq_q[arenc_pkg::PROD_W-2:0], fits};
      cnt_d = cnt_q + arenc_pkg::DIV_CNT_W'(1);
      if (cnt_q == arenc_pkg::DIV_CNT_W'(arenc_pkg::PROD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q[arenc_pkg::RANGE_W-1:0];

endmodule

[src/arenc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arenc_front
// Input side: takes transactions, sorts them into encode, skip (zero total)
// and finish, and queues them for the back end.
// ----------------------------------------------------------------------------
module arenc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  arenc_pkg::in_item_t    in_data_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output arenc_pkg::queue_item_t q_item_o
);

  arenc_pkg::queue_item_t             entry_q [arenc_pkg::QUEUE_DEPTH];
  logic [arenc_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [arenc_pkg::QCNT_W-1:0]       count_q;
  arenc_pkg::queue_item_t             classified;
  logic                               push, pop;

  always_comb begin
    classified.cum_low   = in_data_i.cum_low;
    classified.cum_high  = in_data_i.cum_high;
    classified.cum_total = in_data_i.cum_total;
    if (in_data_i.command == arenc_pkg::CMD_FINISH) begin
      classified.kind = arenc_pkg::KIND_FINISH;
    end else if (in_data_i.cum_total == '0) begin
      classified.kind = arenc_pkg::KIND_SKIP;
    end else begin
      classified.kind = arenc_pkg::KIND_ENCODE;
    end
  end

  assign in_stall_o = (count_q == arenc_pkg::QCNT_W'(arenc_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == arenc_pkg::QPTR_W'(arenc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + arenc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == arenc_pkg::QPTR_W'(arenc_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + arenc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + arenc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - arenc_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= classified;
    end
  end

endmodule

[src/arenc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arenc_back
// Coding engine: narrows the range with two iterative divisions, then shifts
// out settled and follow bits one per cycle, unless a full output holds them,
// into the byte packer. The last finished byte is held back so it can be tagged as the end of the run.
// ----------------------------------------------------------------------------
module arenc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_pop_o,
  input  arenc_pkg::queue_item_t q_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output arenc_pkg::out_item_t   out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_TOP,
    ST_FOLLOW,
    ST_LOOP,
    ST_UNDER,
    ST_FIN_FIRST,
    ST_FIN_OPP,
    ST_FIN_PAD,
    ST_END
  } state_e;

  state_e                 state_q, state_d;
  arenc_pkg::queue_item_t item_q, item_d;
  logic [16:0]            r_q, r_d;
  logic [15:0]            high_q, high_d;
  logic [15:0]            low_q, low_d;
  logic [7:0]             pend_q, pend_d;
  logic [8:0]             pack_q, pack_d;
  logic [8:0]             cnt_q, cnt_d;
  logic                   sticky_q, sticky_d;
  logic                   held_valid_q, held_valid_d;
  logic [7:0]             held_byte_q, held_byte_d;
  logic                   out_valid_q, out_valid_d;
  arenc_pkg::out_item_t   out_data_q, out_data_d;

  logic        can_load;
  logic        push_en, push_val, push_ok, byte_done;
  logic [8:0]  pack_shift;
  logic        div_start, done_hi, done_lo;
  logic [15:0] quot_hi, quot_lo;
  logic [arenc_pkg::PROD_W-1:0] prod_hi, prod_lo;
  logic [15:0] new_high, new_low;

  assign can_load   = !out_valid_q || !out_stall_i;
  assign pack_shift = {pack_q[7:0], push_val};
  assign byte_done  = pack_shift[8];
  // A completed byte pushes the held one out, which needs a free output slot.
  assign push_ok    = !(byte_done && held_valid_q && !can_load);

  // r is at most 2^16 and the cumulative count below 2^16: fits 32 bits.
  assign prod_hi  = arenc_pkg::PROD_W'(r_q) * arenc_pkg::PROD_W'(item_q.cum_high);
  assign prod_lo  = arenc_pkg::PROD_W'(r_q) * arenc_pkg::PROD_W'(item_q.cum_low);
  assign new_high = quot_hi - 16'd1 + low_q;
  assign new_low  = low_q + quot_lo;

  arenc_div u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_hi),
    .divisor_i  (item_q.cum_total),
    .done_o     (done_hi),
    .quot_o     (quot_hi)
  );

  arenc_div u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_lo),
    .divisor_i  (item_q.cum_total),
    .done_o     (done_lo),
    .quot_o     (quot_lo)
  );

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    r_d          = r_q;
    high_d       = high_q;
    low_d        = low_q;
    pend_d       = pend_q;
    pack_d       = pack_q;
    cnt_d        = cnt_q;
    sticky_d     = sticky_q;
    held_valid_d = held_valid_q;
    held_byte_d  = held_byte_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    q_pop_o      = 1'b0;
    div_start    = 1'b0;
    push_en      = 1'b0;
    push_val     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          r_d     = {1'b0, high_q - low_q} + 17'd1;
          case (q_item_i.kind)
            arenc_pkg::KIND_FINISH: state_d = ST_FIN_FIRST;
            arenc_pkg::KIND_ENCODE: state_d = ST_MUL;
            default:                state_d = ST_END;
          endcase
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (done_hi && done_lo) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        high_d  = new_high;
        low_d   = new_low;
        state_d = ((new_high[15] ^ new_low[15]) == 1'b0) ? ST_TOP : ST_UNDER;
      end
      ST_TOP: begin
        push_en  = 1'b1;
        push_val = low_q[15];
        if (push_ok) begin
          state_d = ST_FOLLOW;
        end
      end
      ST_FOLLOW: begin
        if (pend_q != '0) begin
          push_en  = 1'b1;
          push_val = ~low_q[15];
          if (push_ok) begin
            pend_d = pend_q - 8'd1;
          end
        end else begin
          low_d   = {low_q[14:0], 1'b0};
          high_d  = {high_q[14:0], 1'b1};
          state_d = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if ((high_q[15] ^ low_q[15]) == 1'b0) begin
          push_en  = 1'b1;
          push_val = low_q[15];
          if (push_ok) begin
            low_d  = {low_q[14:0], 1'b0};
            high_d = {high_q[14:0], 1'b1};
          end
        end else begin
          state_d = ST_UNDER;
        end
      end
      ST_UNDER: begin
        // Underflow: low = 01.., high = 10.. drops the second bit.
        if (low_q[14] && !high_q[14]) begin
          if (pend_q < arenc_pkg::FOLLOW_MAX) begin
            pend_d = pend_q + 8'd1;
          end else begin
            sticky_d = 1'b1;
          end
          low_d  = {1'b0, low_q[13:0], 1'b0};
          high_d = {1'b1, high_q[13:0], 1'b1};
        end else begin
          state_d = ST_END;
        end
      end
      ST_FIN_FIRST: begin
        push_en  = 1'b1;
        push_val = low_q[14];
        if (push_ok) begin
          cnt_d   = {1'b0, pend_q} + 9'd1;
          state_d = ST_FIN_OPP;
        end
      end
      ST_FIN_OPP: begin
        if (cnt_q != '0) begin
          push_en  = 1'b1;
          push_val = ~low_q[14];
          if (push_ok) begin
            cnt_d = cnt_q - 9'd1;
          end
        end else begin
          state_d = ST_FIN_PAD;
        end
      end
      ST_FIN_PAD: begin
        // Zero padding until the partial byte completes.
        if (pack_q != arenc_pkg::PACK_INIT) begin
          push_en  = 1'b1;
          push_val = 1'b0;
        end else begin
          high_d  = arenc_pkg::RANGE_HIGH_INIT;
          low_d   = arenc_pkg::RANGE_LOW_INIT;
          pend_d  = '0;
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (can_load) begin
          out_valid_d                = 1'b1;
          out_data_d.byte_valid      = held_valid_q;
          out_data_d.out_byte        = held_valid_q ? held_byte_q : 8'h00;
          out_data_d.last_of_run     = 1'b1;
          out_data_d.follow_overflow = sticky_q;
          held_valid_d               = 1'b0;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (push_en && push_ok) begin
      if (byte_done) begin
        pack_d       = arenc_pkg::PACK_INIT;
        held_valid_d = 1'b1;
        held_byte_d  = pack_shift[7:0];
        if (held_valid_q) begin
          out_valid_d                = 1'b1;
          out_data_d.byte_valid      = 1'b1;
          out_data_d.out_byte        = held_byte_q;
          out_data_d.last_of_run     = 1'b0;
          out_data_d.follow_overflow = sticky_q;
        end
      end else begin
        pack_d = pack_shift;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      r_q          <= '0;
      high_q       <= arenc_pkg::RANGE_HIGH_INIT;
      low_q        <= arenc_pkg::RANGE_LOW_INIT;
      pend_q       <= '0;
      pack_q       <= arenc_pkg::PACK_INIT;
      cnt_q        <= '0;
      sticky_q     <= 1'b0;
      held_valid_q <= 1'b0;
      held_byte_q  <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      item_q       <= item_d;
      r_q          <= r_d;
      high_q       <= high_d;
      low_q        <= low_d;
      pend_q       <= pend_d;
      pack_q       <= pack_d;
      cnt_q        <= cnt_d;
      sticky_q     <= sticky_d;
      held_valid_q <= held_valid_d;
      held_byte_q  <= held_byte_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[src/arith_range_encoder_16bit_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arith_range_encoder_16bit_top
// 16-bit binary arithmetic encoder with bit-plus-follow underflow handling,
// MSB-first byte output and a flush command.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid_i/in_stall_o | in_data_i  (command, cum_low/high/total)
//  out     | out_valid_o/out_stall_i | out_data_o (byte, last, overflow flag)
//
// Encode: a multiply and two parallel 32-step dividers, then the coded bits
// and underflow steps are shifted out. Finish: the flushed and padding bits.
// Skip (zero total): goes straight to the end-of-run output.
// Reset leaves the coder initialized (full range, nothing pending).
// A two-entry queue takes new transactions while the engine works; a stalled
// output only halts the engine when a further result (byte or status) is ready.
// ----------------------------------------------------------------------------
module arith_range_encoder_16bit_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  arenc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output arenc_pkg::out_item_t out_data_o
);

  logic                   q_valid;
  logic                   q_pop;
  arenc_pkg::queue_item_t q_item;

  arenc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  arenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
